// ===== sv/drt_pkg.sv =====
// drt_pkg: shared types and codes for the device registry table
// no dependencies
package drt_pkg;

  localparam int DEF_TABLE_ENTRIES = 128;

  localparam logic [2:0] CMD_JOIN_REQ  = 3'd0;
  localparam logic [2:0] CMD_JOIN_CONF = 3'd1;
  localparam logic [2:0] CMD_FIND_UC   = 3'd2;
  localparam logic [2:0] CMD_REMOVE    = 3'd3;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
  localparam logic [2:0] CMD_READ_KEY  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic        used;
    logic [7:0]  stype;
    logic [31:0] unicast;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] mac;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

// ===== sv/drt_cell.sv =====
// drt_cell: one table slot in the rotating ring of cells
// depends on drt_pkg
module drt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            clear,
  input  drt_pkg::entry_t d,
  output drt_pkg::entry_t q
);
  import drt_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ===== sv/device_registry_table.sv =====
// device_registry_table: top level, ring of slot cells plus command sequencer
// depends on drt_pkg and drt_cell
//
// one request on the in_ stream gives exactly one result on the out_ stream.
// the slots sit in a ring of cells that rotates by one place a cycle during
// a pass; at the end of a pass every slot is back where it started and
// the head cell has shown slot k at pass step k. all reads, compares and
// writes happen at the head cell only, but clear all zeroes every cell.
// clear all and rejected requests go from idle straight to the done state;
// find unicast, join confirm, remove slot and read key make one pass of the
// ring, as does a join request; one for a new mac with a free slot makes
// a second pass to store the mac. one request is in work at a time, so a
// new request is taken only once the last one has reached the done state.
// reset clears every slot, the unicast counter and the pending join, and
// empties the result register.
// if the receiver stalls, the finished result waits in the output register;
// a new request can be taken once that result register is loaded and the
// sequencer is idle, and its own result waits until the register frees.
module device_registry_table #(
  parameter int TABLE_ENTRIES = drt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[2:0], mac[66:3], sensor_type[74:67], key_upper[138:75],
  // key_lower[202:139], unicast_query[234:203], slot_select[241:235]
  input  logic [247:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], slot_index[8:2], already_known[9], assigned_unicast[41:10],
  // key_out_upper[105:42], key_out_lower[169:106]
  output logic [175:0] out_tdata
);
  import drt_pkg::*;

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

  // input field split
  logic [2:0]  in_cmd;
  logic [63:0] in_mac;
  logic [7:0]  in_stype;
  logic [63:0] in_khi;
  logic [63:0] in_klo;
  logic [31:0] in_query;
  logic [6:0]  in_sel;

  assign in_cmd   = in_tdata[2:0];
  assign in_mac   = in_tdata[66:3];
  assign in_stype = in_tdata[74:67];
  assign in_khi   = in_tdata[138:75];
  assign in_klo   = in_tdata[202:139];
  assign in_query = in_tdata[234:203];
  assign in_sel   = in_tdata[241:235];

  state_t state_r, state_nxt;

  // latched request
  logic [2:0]        cmd_r;
  logic [63:0]       mac_r;
  logic [7:0]        stype_r;
  logic [63:0]       khi_r;
  logic [63:0]       klo_r;
  logic [31:0]       query_r;
  logic [SLOT_W-1:0] sel_r;

  // pass step, equals the slot shown at the head cell
  logic [SLOT_W-1:0] step_r;

  // join search results
  logic              hit_r, free_r;
  logic [SLOT_W-1:0] hit_idx_r, free_idx_r;

  // pending join and counter
  logic              pend_valid_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic              pend_known_r;
  logic [31:0]       uc_cnt_r;

  // result being built
  logic [1:0]  res_status_r;
  logic [6:0]  res_slot_r;
  logic        res_known_r;
  logic [31:0] res_uc_r;
  logic [63:0] res_khi_r;
  logic [63:0] res_klo_r;

  logic         out_tvalid_r;
  logic [175:0] out_tdata_r;

  logic accept;
  logic sel_ok;
  logic rotate;
  logic clear_all;
  logic pass_end;

  // ring of cells
  entry_t cell_q [TABLE_ENTRIES];
  entry_t head;
  entry_t head_nxt;

  assign head = cell_q[0];

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_ring
      entry_t cell_d;
      if (gi == TABLE_ENTRIES - 1) begin : g_tail
        assign cell_d = head_nxt;
      end else begin : g_mid
        assign cell_d = cell_q[gi+1];
      end
      drt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (rotate),
        .clear    (clear_all),
        .d        (cell_d),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  assign accept   = in_tvalid && in_tready;
  assign sel_ok   = 32'(in_sel) < 32'(TABLE_ENTRIES);
  assign pass_end = (step_r == LAST_SLOT);

  // join search including the slot at the head this cycle
  logic              mac_hit_now, free_now;
  logic              hit_c, free_c;
  logic [SLOT_W-1:0] hit_idx_c, free_idx_c;

  assign mac_hit_now = (head.mac == mac_r);
  assign free_now    = !head.used;
  assign hit_c       = hit_r || mac_hit_now;
  assign hit_idx_c   = hit_r ? hit_idx_r : step_r;
  assign free_c      = free_r || free_now;
  assign free_idx_c  = free_r ? free_idx_r : step_r;

  // head cell update on its way round to the tail
  always_comb begin
    head_nxt = head;
    if (state_r == S_SCAN) begin
      case (cmd_r)
        CMD_JOIN_CONF: begin
          if (step_r == pend_slot_r) begin
            head_nxt.used    = 1'b1;
            head_nxt.stype   = stype_r;
            head_nxt.unicast = uc_cnt_r;
            head_nxt.key_hi  = khi_r;
            head_nxt.key_lo  = klo_r;
          end
        end
        CMD_REMOVE: begin
          if (step_r == sel_r) begin
            head_nxt = '0;
          end
        end
        default: ;
      endcase
    end else if (state_r == S_WRITE) begin
      if (step_r == free_idx_r) begin
        head_nxt.mac = mac_r;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_JOIN_REQ, CMD_FIND_UC: state_nxt = S_SCAN;
            CMD_JOIN_CONF:             state_nxt = pend_valid_r ? S_SCAN : S_DONE;
            CMD_REMOVE, CMD_READ_KEY:  state_nxt = sel_ok ? S_SCAN : S_DONE;
            default:                   state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (pass_end) begin
          if (cmd_r == CMD_JOIN_REQ && !hit_c && free_c) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WRITE: begin
        if (pass_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    rotate    = 1'b0;
    clear_all = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        clear_all = in_tvalid && (in_cmd == CMD_CLEAR_ALL);
      end
      S_SCAN, S_WRITE: rotate = 1'b1;
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request latch, search, pending join, counter and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_slot_r  <= '0;
      pend_known_r <= 1'b0;
      uc_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result register: loaded from the done state, else drained on handshake
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= in_cmd;
            mac_r     <= in_mac;
            stype_r   <= in_stype;
            khi_r     <= in_khi;
            klo_r     <= in_klo;
            query_r   <= in_query;
            sel_r     <= SLOT_W'(in_sel);
            step_r    <= '0;
            hit_r     <= 1'b0;
            free_r    <= 1'b0;
            hit_idx_r <= '0;
            free_idx_r <= '0;
            // default answer: not found with all fields zero
            res_status_r <= ST_NOT_FOUND;
            res_slot_r   <= '0;
            res_known_r  <= 1'b0;
            res_uc_r     <= '0;
            res_khi_r    <= '0;
            res_klo_r    <= '0;
            case (in_cmd)
              CMD_JOIN_CONF: begin
                if (pend_valid_r) begin
                  uc_cnt_r     <= uc_cnt_r + 32'd1;
                  res_status_r <= ST_OK;
                  res_slot_r   <= 7'(pend_slot_r);
                  res_known_r  <= pend_known_r;
                  res_uc_r     <= uc_cnt_r + 32'd1;
                  res_khi_r    <= in_khi;
                  res_klo_r    <= in_klo;
                end
              end
              CMD_REMOVE, CMD_READ_KEY: begin
                if (sel_ok) begin
                  res_status_r <= ST_OK;
                  res_slot_r   <= in_sel;
                end
              end
              CMD_CLEAR_ALL: begin
                uc_cnt_r     <= '0;
                pend_valid_r <= 1'b0;
                pend_slot_r  <= '0;
                pend_known_r <= 1'b0;
                res_status_r <= ST_OK;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          step_r <= pass_end ? '0 : step_r + SLOT_W'(1);
          case (cmd_r)
            CMD_JOIN_REQ: begin
              hit_r      <= hit_c;
              hit_idx_r  <= hit_idx_c;
              free_r     <= free_c;
              free_idx_r <= free_idx_c;
              if (pass_end) begin
                if (hit_c) begin
                  pend_valid_r <= 1'b1;
                  pend_slot_r  <= hit_idx_c;
                  pend_known_r <= 1'b1;
                  res_status_r <= ST_OK;
                  res_slot_r   <= 7'(hit_idx_c);
                  res_known_r  <= 1'b1;
                end else if (free_c) begin
                  pend_valid_r <= 1'b1;
                  pend_slot_r  <= free_idx_c;
                  pend_known_r <= 1'b0;
                  res_status_r <= ST_OK;
                  res_slot_r   <= 7'(free_idx_c);
                end else begin
                  pend_valid_r <= 1'b0;
                  pend_known_r <= 1'b0;
                  res_status_r <= ST_FULL;
                end
              end
            end
            CMD_FIND_UC: begin
              // first matching slot wins
              if (res_status_r != ST_OK && head.unicast == query_r) begin
                res_status_r <= ST_OK;
                res_slot_r   <= 7'(step_r);
                res_uc_r     <= query_r;
              end
            end
            CMD_READ_KEY: begin
              if (step_r == sel_r) begin
                res_uc_r  <= head.unicast;
                res_khi_r <= head.key_hi;
                res_klo_r <= head.key_lo;
              end
            end
            default: ;
          endcase
        end
        S_WRITE: begin
          step_r <= pass_end ? '0 : step_r + SLOT_W'(1);
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {6'd0, res_klo_r, res_khi_r, res_uc_r, res_known_r,
                             res_slot_r, res_status_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== dv/drt_checker.sv =====
// drt_checker: watches both streams of the device registry table, predicts
// each result from its own copy of the table and compares; depends on drt_pkg
`timescale 1ns / 100ps
module drt_checker #(
  parameter int TABLE_ENTRIES = drt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [247:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [175:0] out_tdata,
  output int           fail_count,
  output int           waiting
);
  import drt_pkg::*;

  typedef struct packed {
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [31:0] unicast;
    logic        known;
    logic [6:0]  slot;
    logic [1:0]  status;
  } reply_t;

  logic        tbl_used [TABLE_ENTRIES];
  logic [7:0]  tbl_type [TABLE_ENTRIES];
  logic [31:0] tbl_uc   [TABLE_ENTRIES];
  logic [63:0] tbl_khi  [TABLE_ENTRIES];
  logic [63:0] tbl_klo  [TABLE_ENTRIES];
  logic [63:0] tbl_mac  [TABLE_ENTRIES];
  logic        join_open;
  int          join_slot;
  logic        join_known;
  logic [31:0] uc_count;
  reply_t      replies_due [$];

  function automatic void wipe(int s);
    tbl_used[s] = 1'b0; tbl_type[s] = '0; tbl_uc[s] = '0;
    tbl_khi[s] = '0; tbl_klo[s] = '0; tbl_mac[s] = '0;
  endfunction

  function automatic reply_t registry_step(logic [247:0] d);
    reply_t r;
    logic [2:0]  cmd;
    logic [63:0] mac;
    logic [31:0] query;
    int          sel;
    int          hit;
    cmd = d[2:0]; mac = d[66:3]; query = d[234:203]; sel = int'(d[241:235]);
    r = '0;
    r.status = ST_NOT_FOUND;
    hit = -1;
    case (cmd)
      CMD_JOIN_REQ: begin
        for (int s = 0; s < TABLE_ENTRIES; s++)
          if (hit < 0 && tbl_mac[s] == mac) hit = s;
        if (hit >= 0) begin
          join_open = 1'b1; join_slot = hit; join_known = 1'b1;
          r.status = ST_OK; r.slot = 7'(hit); r.known = 1'b1;
        end else begin
          for (int s = 0; s < TABLE_ENTRIES; s++)
            if (hit < 0 && !tbl_used[s]) hit = s;
          if (hit >= 0) begin
            tbl_mac[hit] = mac;
            join_open = 1'b1; join_slot = hit; join_known = 1'b0;
            r.status = ST_OK; r.slot = 7'(hit);
          end else begin
            join_open = 1'b0; join_known = 1'b0;
            r.status = ST_FULL;
          end
        end
      end
      CMD_JOIN_CONF: begin
        if (join_open) begin
          tbl_type[join_slot] = d[74:67];
          tbl_khi[join_slot] = d[138:75];
          tbl_klo[join_slot] = d[202:139];
          tbl_used[join_slot] = 1'b1;
          uc_count = uc_count + 32'd1;
          tbl_uc[join_slot] = uc_count;
          r.status = ST_OK; r.slot = 7'(join_slot); r.known = join_known;
          r.unicast = uc_count; r.key_hi = d[138:75]; r.key_lo = d[202:139];
        end
      end
      CMD_FIND_UC: begin
        for (int s = 0; s < TABLE_ENTRIES; s++)
          if (hit < 0 && tbl_uc[s] == query) hit = s;
        if (hit >= 0) begin
          r.status = ST_OK; r.slot = 7'(hit); r.unicast = query;
        end
      end
      CMD_REMOVE: begin
        if (sel < TABLE_ENTRIES) begin
          wipe(sel);
          r.status = ST_OK; r.slot = 7'(sel);
        end
      end
      CMD_CLEAR_ALL: begin
        for (int s = 0; s < TABLE_ENTRIES; s++) wipe(s);
        uc_count = '0; join_open = 1'b0; join_slot = 0; join_known = 1'b0;
        r.status = ST_OK;
      end
      CMD_READ_KEY: begin
        if (sel < TABLE_ENTRIES) begin
          r.status = ST_OK; r.slot = 7'(sel); r.unicast = tbl_uc[sel];
          r.key_hi = tbl_khi[sel]; r.key_lo = tbl_klo[sel];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want, got;
    if (!rst_n) begin
      for (int s = 0; s < TABLE_ENTRIES; s++) wipe(s);
      join_open = 1'b0; join_slot = 0; join_known = 1'b0; uc_count = '0;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) replies_due.push_back(registry_step(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[169:0];
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected st=%0d slot=%0d kn=%0d uc=%h k=%h_%h",
                     $time, want.status, want.slot, want.known, want.unicast,
                     want.key_hi, want.key_lo);
            $display("%0t:          actual   st=%0d slot=%0d kn=%0d uc=%h k=%h_%h",
                     $time, got.status, got.slot, got.known, got.unicast,
                     got.key_hi, got.key_lo);
            fail_count++;
          end
        end
      end
    end
    waiting = replies_due.size();
  end
endmodule

// ===== dv/tb_device_registry_table.sv =====
// tb_device_registry_table: stimulus and verdict for the device registry table
// depends on drt_pkg, device_registry_table and drt_checker
`timescale 1ns / 100ps
module tb_device_registry_table;
  import drt_pkg::*;

  localparam int N = DEF_TABLE_ENTRIES;
  localparam int CYCLE_LIMIT = 6_000_000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [247:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [175:0] out_tdata;
  int           fail_count;
  int           waiting;
  int           cycles = 0;
  logic [63:0]  macs_seen [$];

  always #10 clk = ~clk;

  device_registry_table dut (.*);

  drt_checker chk (.*);

  // every run of the clock counts towards the timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_device_registry_table: errors");
      $finish;
    end
  end

  // receiver: random stall per result, with quiet stretches of full throttle
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one request: optional idle gap, then hold tvalid until accepted
  task automatic send_request(logic [2:0] cmd, logic [63:0] mac, logic [7:0] stype,
                              logic [63:0] khi, logic [63:0] klo,
                              logic [31:0] query, logic [6:0] sel, bit idle_ok);
    int gap;
    gap = idle_ok ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {6'b0, sel, query, klo, khi, stype, mac, cmd};
    in_tvalid <= 1;
    @(posedge clk iff in_tready);
  endtask

  // random request biased towards join request / confirm pairs
  task automatic random_request(bit idle_ok);
    logic [63:0] mac;
    logic [2:0]  cmd;
    int          pick;
    pick = $urandom_range(0, 99);
    mac = rand64();
    if (macs_seen.size() > 0 && $urandom_range(0, 2) == 0)
      mac = macs_seen[$urandom_range(0, macs_seen.size() - 1)];
    else if ($urandom_range(0, 30) == 0)
      mac = '0;
    if (pick < 35) begin
      send_request(CMD_JOIN_REQ, mac, 8'($urandom()), rand64(), rand64(),
                   $urandom(), 7'($urandom()), idle_ok);
      macs_seen.push_back(mac);
      cmd = CMD_JOIN_CONF;
      if ($urandom_range(0, 9) == 0) return;
    end else if (pick < 50) cmd = CMD_JOIN_CONF;
    else if (pick < 65) cmd = CMD_FIND_UC;
    else if (pick < 77) cmd = CMD_REMOVE;
    else if (pick < 92) cmd = CMD_READ_KEY;
    else if (pick < 94) cmd = CMD_CLEAR_ALL;
    else if (pick < 97) cmd = 3'($urandom_range(6, 7));
    else cmd = CMD_JOIN_REQ;
    send_request(cmd, mac, 8'($urandom()), rand64(), rand64(),
                 ($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom()),
                 7'($urandom()), idle_ok);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every command and the corner cases
    send_request(CMD_JOIN_CONF, '0, '0, '0, '0, '0, '0, 1);         // confirm, no join
    send_request(CMD_READ_KEY, '0, '0, '0, '0, '0, '0, 1);          // never-written slot
    send_request(CMD_FIND_UC, '0, '0, '0, '0, '0, '0, 0);           // zero query hits slot 0
    send_request(CMD_JOIN_REQ, '0, '0, '0, '0, '0, '0, 0);          // zero mac matches
    send_request(CMD_JOIN_REQ, '1, '1, '1, '1, '1, '1, 0);
    send_request(CMD_JOIN_CONF, '1, '1, '1, '1, '1, '1, 0);
    send_request(CMD_JOIN_CONF, '0, 8'h5a, rand64(), rand64(), '0, '0, 0); // repeat confirm
    send_request(CMD_READ_KEY, '0, '0, '0, '0, '0, 7'd127, 1);
    send_request(CMD_FIND_UC, '0, '0, '0, '0, 32'd2, '0, 1);
    send_request(CMD_FIND_UC, '0, '0, '0, '0, '1, '0, 1);
    send_request(CMD_REMOVE, '0, '0, '0, '0, '0, 7'd127, 1);
    send_request(CMD_REMOVE, '0, '0, '0, '0, '0, 7'd0, 1);
    send_request(CMD_JOIN_REQ, '1, '0, '0, '0, '0, '0, 1);          // mac left unconfirmed
    send_request(3'd6, '1, '1, '1, '1, '1, '1, 1);
    send_request(3'd7, '0, '0, '0, '0, '0, '0, 1);
    send_request(CMD_CLEAR_ALL, '1, '1, '1, '1, '1, '1, 1);
    send_request(CMD_JOIN_CONF, '0, '0, '0, '0, '0, '0, 1);         // pending cleared

    // fill the table, then a new mac must see it full
    for (int s = 0; s < N; s++) begin
      send_request(CMD_JOIN_REQ, rand64() | 64'h1, '0, '0, '0, '0, '0, 0);
      send_request(CMD_JOIN_CONF, '0, 8'($urandom()), rand64(), rand64(), '0, '0, 0);
    end
    send_request(CMD_JOIN_REQ, 64'h0, '0, '0, '0, '0, '0, 0);
    send_request(CMD_JOIN_REQ, 64'h1234_5678_9abc_def0, '0, '0, '0, '0, '0, 1);
    send_request(CMD_JOIN_CONF, '0, '0, '0, '0, '0, '0, 1);         // after table full
    send_request(CMD_REMOVE, '0, '0, '0, '0, '0, 7'd64, 1);
    send_request(CMD_JOIN_REQ, 64'h1234_5678_9abc_def0, '0, '0, '0, '0, '0, 1);

    // random traffic, idling on about three requests in four
    for (int i = 0; i < 970; i++)
      random_request($urandom_range(0, 3) != 0);
    in_tvalid <= 0;

    wait (waiting == 0);
    repeat (2 * N + 10) @(posedge clk);
    if (fail_count == 0 && waiting == 0)
      $display("tb_device_registry_table: clean");
    else
      $display("tb_device_registry_table: errors");
    $finish;
  end
endmodule

// ===== files.f =====
sv/drt_pkg.sv
sv/drt_cell.sv
sv/device_registry_table.sv
dv/drt_checker.sv
dv/tb_device_registry_table.sv
